// ===== hdl/sip24_pkg.sv =====
package sip24_pkg;

  // SipHash initialisation constants and the finalisation marker.
  localparam logic [63:0] SipC0  = 64'h736f6d6570736575;
  localparam logic [63:0] SipC1  = 64'h646f72616e646f6d;
  localparam logic [63:0] SipC2  = 64'h6c7967656e657261;
  localparam logic [63:0] SipC3  = 64'h7465646279746573;
  localparam logic [63:0] SipFin = 64'h00000000000000ff;

  // Default depths of the command and result queues.
  localparam int unsigned CmdDepthDefault = 2;
  localparam int unsigned ResDepthDefault = 2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_SHIFT_MODE = 2'd2
  } cfg_idx_e;

  // Full message word size in bytes.
  localparam logic [3:0] WordBytes = 4'd8;

  // The four SipHash lanes.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  // Command handed from the front end to the hash engine.
  typedef struct packed {
    logic        use_init;  // start from the key rather than the saved lanes
    logic        absorb;    // mix in word as a full block first
    logic        finish;    // close with fin_word and emit a digest
    logic [63:0] word;
    logic [63:0] fin_word;
  } cmd_t;

  // Steps of the engine, one SipRound each.
  typedef enum logic [2:0] {
    ST_ABS0,
    ST_ABS1,
    ST_FIN0,
    ST_FIN1,
    ST_END0,
    ST_END1,
    ST_END2,
    ST_END3
  } step_e;

  function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic lanes_t sip_round(lanes_t s);
    lanes_t t;
    t   = s;
    t.a = t.a + t.b;
    t.b = rotl64(t.b, 13) ^ t.a;
    t.a = rotl64(t.a, 32);
    t.c = t.c + t.d;
    t.d = rotl64(t.d, 16) ^ t.c;
    t.a = t.a + t.d;
    t.d = rotl64(t.d, 21) ^ t.a;
    t.c = t.c + t.b;
    t.b = rotl64(t.b, 17) ^ t.c;
    t.c = rotl64(t.c, 32);
    return t;
  endfunction

endpackage

// ===== hdl/sip24_fifo.sv =====
module sip24_fifo #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; only filled entries are ever read out.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/sip24_front.sv =====
module sip24_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               func_i,
  input  logic [63:0]        word_i,
  input  logic [3:0]         byte_count_i,
  input  logic               last_i,
  input  logic               shift_mode_i,
  output sip24_pkg::cmd_t    cmd_o
);
  import sip24_pkg::*;

  logic       open_q, open_d;
  logic [7:0] tally_q, tally_d;

  logic [3:0]  count_sat;
  logic        full_word;
  logic        closes;
  logic [3:0]  tail;
  logic [63:0] mask;
  logic [7:0]  tally_new;
  logic [63:0] len_bits;

  // Saturate the byte count and work out whether the item ends the message.
  always_comb begin
    count_sat = (byte_count_i > WordBytes) ? WordBytes : byte_count_i;
    full_word = (count_sat == WordBytes);
    closes    = last_i | ~full_word;
    tail      = full_word ? 4'd0 : count_sat;
    tally_new = (open_q ? tally_q : 8'd0) + {7'd0, full_word};
  end

  // Byte mask for the tail bytes.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < tail) ? 8'hff : 8'h00;
    end
  end

  // Block count placed in the top bits of the final word.
  assign len_bits = shift_mode_i ? {tally_new[4:0], 59'd0} : {tally_new, 56'd0};

  // Build the command for the engine.
  always_comb begin
    if (func_i) begin
      cmd_o.use_init = 1'b1;
      cmd_o.absorb   = 1'b0;
      cmd_o.finish   = 1'b1;
      cmd_o.word     = word_i;
      cmd_o.fin_word = word_i;
    end else begin
      cmd_o.use_init = ~open_q;
      cmd_o.absorb   = full_word;
      cmd_o.finish   = closes;
      cmd_o.word     = word_i;
      cmd_o.fin_word = len_bits | (word_i & mask);
    end
  end

  // Message tracking; a one-shot hash leaves it alone.
  always_comb begin
    open_d  = open_q;
    tally_d = tally_q;
    if (accept_i && !func_i) begin
      if (closes) begin
        open_d  = 1'b0;
        tally_d = 8'd0;
      end else begin
        open_d  = 1'b1;
        tally_d = tally_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      tally_q <= 8'd0;
    end else begin
      open_q  <= open_d;
      tally_q <= tally_d;
    end
  end

endmodule

// ===== hdl/sip24_back.sv =====
module sip24_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sip24_pkg::cmd_t cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  input  logic [63:0]     key_low_i,
  input  logic [63:0]     key_high_i,
  input  logic            res_full_i,
  output logic            res_push_o,
  output logic [63:0]     res_data_o
);
  import sip24_pkg::*;

  logic   busy_q, busy_d;
  step_e  step_q, step_d;
  cmd_t   cur_q;
  lanes_t work_q, work_d;
  lanes_t msg_q, msg_d;

  cmd_t   cmd;
  step_e  step;
  logic   active, stall, run, done;
  lanes_t init, src, base, rin, rout;
  logic [63:0] xa, xc, xd;
  logic   store_msg;

  // Select the command and step that run in this cycle.
  always_comb begin
    cmd    = busy_q ? cur_q : cmd_i;
    step   = busy_q ? step_q : (cmd_i.absorb ? ST_ABS0 : ST_FIN0);
    active = busy_q | cmd_valid_i;
    stall  = (step == ST_END3) & res_full_i;
    run    = active & ~stall;
  end

  assign cmd_pop_o = ~busy_q & cmd_valid_i & ~stall;

  // Next step.
  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done   = 1'b0;
    case (step)
      ST_ABS0: step_d = ST_ABS1;
      ST_ABS1: begin
        step_d = ST_FIN0;
        done   = ~cmd.finish;
      end
      ST_FIN0: step_d = ST_FIN1;
      ST_FIN1: step_d = ST_END0;
      ST_END0: step_d = ST_END1;
      ST_END1: step_d = ST_END2;
      ST_END2: step_d = ST_END3;
      ST_END3: done   = 1'b1;
      default: step_d = ST_ABS0;
    endcase
    if (run) begin
      busy_d = ~done;
    end else begin
      step_d = step_q;
    end
  end

  // Round input selection and per-step lane injections.
  always_comb begin
    init.a = SipC0 ^ key_low_i;
    init.b = SipC1 ^ key_high_i;
    init.c = SipC2 ^ key_low_i;
    init.d = SipC3 ^ key_high_i;
    src    = cmd.use_init ? init : msg_q;
    base   = work_q;
    xa     = '0;
    xc     = '0;
    xd     = '0;
    store_msg  = 1'b0;
    res_push_o = 1'b0;
    case (step)
      ST_ABS0: begin
        base = src;
        xd   = cmd.word;
      end
      ST_ABS1: store_msg = run & ~cmd.finish;
      ST_FIN0: begin
        base = cmd.absorb ? work_q : src;
        xa   = cmd.absorb ? cmd.word : 64'd0;
        xd   = cmd.fin_word;
      end
      ST_END0: begin
        xa = cmd.fin_word;
        xc = SipFin;
      end
      ST_END3: res_push_o = run;
      default: base = work_q;
    endcase
    rin.a = base.a ^ xa;
    rin.b = base.b;
    rin.c = base.c ^ xc;
    rin.d = base.d ^ xd;
  end

  assign rout       = sip_round(rin);
  assign res_data_o = rout.a ^ rout.b ^ rout.c ^ rout.d;

  // Lane updates; the saved message lanes change only when a word ends open.
  always_comb begin
    work_d = work_q;
    msg_d  = msg_q;
    if (run) begin
      work_d = rout;
    end
    if (store_msg) begin
      msg_d   = rout;
      msg_d.a = rout.a ^ cmd.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_ABS0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    msg_q  <= msg_d;
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

endmodule

// ===== hdl/siphash_2_4_stream_top.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         push / full               func_i, word_i, byte_count_i, last_i
// result    out        empty / pop               digest_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A full message word is mixed in with two SipRounds in the engine, one SipRound a
// cycle, and the engine ends one command before it takes the next. A closing item or
// one-shot hash runs two absorb rounds for any full word, two absorb rounds for the
// final word and four finalisation rounds, all on the single round unit.
// The command queue lets items be taken while the engine runs; the engine
// stalls only on its last round if the result queue is full. Reset clears
// all control state and the key registers; it needs no clearing pass.
module siphash_2_4_stream_top #(
  parameter int unsigned CmdDepth = sip24_pkg::CmdDepthDefault,
  parameter int unsigned ResDepth = sip24_pkg::ResDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      func_i,
  input  logic [63:0]               word_i,
  input  logic [3:0]                byte_count_i,
  input  logic                      last_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [63:0]               digest_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sip24_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]               cfg_data_i
);
  import sip24_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);

  logic [63:0] key_low_q, key_high_q;
  logic        shift_mode_q;
  logic        in_accept;
  cmd_t        front_cmd, back_cmd;
  logic        cmd_full, cmd_empty, cmd_pop;
  logic        res_full, res_push;
  logic [63:0] res_data;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= '0;
      key_high_q   <= '0;
      shift_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KEY_LOW:    key_low_q    <= cfg_data_i;
        CFG_KEY_HIGH:   key_high_q   <= cfg_data_i;
        CFG_SHIFT_MODE: shift_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input transfer.
  assign full      = cmd_full;
  assign in_accept = push & ~cmd_full;

  sip24_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .func_i       (func_i),
    .word_i       (word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .shift_mode_i (shift_mode_q),
    .cmd_o        (front_cmd)
  );

  sip24_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  sip24_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (~cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  sip24_fifo #(
    .Width (64),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (digest_o),
    .empty_o (empty)
  );

  // An accepted item is waiting in the command queue on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !cmd_empty)
    else $error("accepted item missing from command queue");

  // The engine never pushes a digest into a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("digest pushed into full result queue");

  // The engine only takes a command that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

endmodule

// ===== tb/sv/siphash_2_4_stream_top_test.sv =====
`timescale 1ns / 1ps

module siphash_2_4_stream_top_test;
  import sip24_pkg::*;

  // SipHash initial vector words and the finalisation marker.
  localparam logic [63:0] IvLane0   = 64'h736f6d6570736575;
  localparam logic [63:0] IvLane1   = 64'h646f72616e646f6d;
  localparam logic [63:0] IvLane2   = 64'h6c7967656e657261;
  localparam logic [63:0] IvLane3   = 64'h7465646279746573;
  localparam logic [63:0] FinMarker = 64'h00000000000000ff;

  localparam int unsigned SettleCycles = 40;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned ItemTarget   = 1750;
  localparam int unsigned RandomPhases = 6;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } hash_lanes_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        func_i;
  logic [63:0] word_i;
  logic [3:0]  byte_count_i;
  logic        last_i;
  logic        empty;
  logic        pop;
  logic [63:0] digest_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i;
  logic [63:0] cfg_data_i;

  // Predicted register contents and message state.
  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;
  logic        wide_shift_q;
  hash_lanes_t msg_lanes;
  logic [7:0]  msg_blocks;
  logic        msg_open;
  logic [63:0] pending_digests[$];

  logic [63:0] digest_want;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned stall_cycles;
  logic        steady_flow;

  siphash_2_4_stream_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .word_i       (word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .empty        (empty),
    .pop          (pop),
    .digest_o     (digest_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Rotation done on a doubled word, keeping the upper half.
  function automatic logic [63:0] rol(input logic [63:0] x, input int unsigned r);
    logic [127:0] wide;
    wide = {x, x} << r;
    return wide[127:64];
  endfunction

  // One SipRound over the four lanes.
  function automatic hash_lanes_t sip_step(input hash_lanes_t s);
    hash_lanes_t t;
    t    = s;
    t.v0 = t.v0 + t.v1;
    t.v1 = rol(t.v1, 13) ^ t.v0;
    t.v0 = rol(t.v0, 32);
    t.v2 = t.v2 + t.v3;
    t.v3 = rol(t.v3, 16) ^ t.v2;
    t.v0 = t.v0 + t.v3;
    t.v3 = rol(t.v3, 21) ^ t.v0;
    t.v2 = t.v2 + t.v1;
    t.v1 = rol(t.v1, 17) ^ t.v2;
    t.v2 = rol(t.v2, 32);
    return t;
  endfunction

  // Lanes loaded from the key currently held in the registers.
  function automatic hash_lanes_t keyed_lanes();
    hash_lanes_t t;
    t.v0 = IvLane0 ^ key_lo_q;
    t.v1 = IvLane1 ^ key_hi_q;
    t.v2 = IvLane2 ^ key_lo_q;
    t.v3 = IvLane3 ^ key_hi_q;
    return t;
  endfunction

  // Compression of one 64-bit block with two rounds.
  function automatic hash_lanes_t mix_in(input hash_lanes_t s, input logic [63:0] m);
    hash_lanes_t t;
    t    = s;
    t.v3 = t.v3 ^ m;
    t    = sip_step(sip_step(t));
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

  // Final block, four finalisation rounds and the folded digest.
  function automatic logic [63:0] seal(input hash_lanes_t s, input logic [63:0] fin);
    hash_lanes_t t;
    t    = mix_in(s, fin);
    t.v2 = t.v2 ^ FinMarker;
    repeat (4) t = sip_step(t);
    return t.v0 ^ t.v1 ^ t.v2 ^ t.v3;
  endfunction

  // Updates the predicted state for one accepted item and queues any digest.
  task automatic predict_item(input logic fn, input logic [63:0] w, input logic [3:0] cnt,
                              input logic lst);
    hash_lanes_t s;
    logic [3:0]  n;
    logic [63:0] keep;
    logic [63:0] fin;
    if (fn) begin
      pending_digests.push_back(seal(keyed_lanes(), w));
      return;
    end
    n = (cnt > WordBytes) ? WordBytes : cnt;
    if (!msg_open) begin
      s          = keyed_lanes();
      msg_blocks = 8'd0;
      msg_open   = 1'b1;
    end else begin
      s = msg_lanes;
    end
    if (n == WordBytes) begin
      s          = mix_in(s, w);
      msg_blocks = msg_blocks + 8'd1;
    end
    if (lst || n < WordBytes) begin
      // A full last word leaves an empty tail; the block count sits in the top bits.
      keep = (n == WordBytes) ? 64'd0 : ((64'd1 << (8 * n)) - 64'd1);
      fin  = ({56'd0, msg_blocks} << (wide_shift_q ? 59 : 56)) | (w & keep);
      pending_digests.push_back(seal(s, fin));
      msg_lanes  = '0;
      msg_blocks = 8'd0;
      msg_open   = 1'b0;
    end else begin
      msg_lanes = s;
    end
  endtask

  function automatic void note_failure(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // Mostly random words, with the all-zero and all-one extremes now and then.
  function automatic logic [63:0] any_word();
    case ($urandom_range(15))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Presents one item, after a random gap, and holds it until the transfer.
  task automatic send_item(input logic fn, input logic [63:0] w, input logic [3:0] cnt,
                           input logic lst);
    while (!steady_flow && $urandom_range(99) < 35) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    push         = 1'b1;
    func_i       = fn;
    word_i       = w;
    byte_count_i = cnt;
    last_i       = lst;
    do @(posedge clk_i); while (full);
    predict_item(fn, w, cnt, lst);
    items_sent++;
  endtask

  // Stops sending and waits until the block has nothing left to do.
  task automatic settle();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_KEY_LOW:    key_lo_q = val;
      CFG_KEY_HIGH:   key_hi_q = val;
      CFG_SHIFT_MODE: wide_shift_q = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] mode);
    write_register(CFG_KEY_LOW, k0);
    write_register(CFG_KEY_HIGH, k1);
    write_register(CFG_SHIFT_MODE, mode);
  endtask

  // A message of full words with random content, closed in one of several ways.
  task automatic send_message(input int unsigned blocks);
    int unsigned k;
    logic [63:0] w;
    for (k = 0; k < blocks; k++) begin
      if ($urandom_range(19) == 0) begin
        send_item(1'b1, any_word(), 4'($urandom_range(15)), 1'($urandom_range(1)));
      end
      send_item(1'b0, any_word(),
                ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : WordBytes, 1'b0);
    end
    w = any_word();
    case ($urandom_range(9))
      0: send_item(1'b0, w, WordBytes, 1'b1);
      1: send_item(1'b0, w, 4'($urandom_range(7)), 1'b0);
      2: send_item(1'b0, w, 4'($urandom_range(9, 15)), 1'b1);
      default: send_item(1'b0, w, 4'($urandom_range(7)), 1'b1);
    endcase
  endtask

  // Hashing with the key left at its reset value.
  task automatic test_reset_key();
    send_item(1'b1, 64'd0, 4'd0, 1'b0);
    send_item(1'b1, '1, 4'hf, 1'b1);
    send_item(1'b0, 64'h0706050403020100, WordBytes, 1'b0);
    send_item(1'b0, '1, 4'd7, 1'b1);
  endtask

  // Every tail length, the over-long count and the short item that is not marked last.
  task automatic test_message_tails();
    int unsigned n;
    settle();
    configure({$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
    for (n = 0; n <= 8; n++) send_item(1'b0, '1, 4'(n), 1'b1);
    send_item(1'b0, any_word(), 4'hf, 1'b1);
    send_item(1'b0, any_word(), 4'd9, 1'b0);
    send_item(1'b0, '1, 4'd3, 1'b0);
    send_item(1'b0, any_word(), WordBytes, 1'b0);
    send_item(1'b0, any_word(), 4'd0, 1'b1);
  endtask

  // A key written while a message is open must only apply to the next message.
  task automatic test_key_change_mid_message();
    settle();
    configure('1, 64'd0, 64'd1);
    send_item(1'b0, any_word(), WordBytes, 1'b0);
    settle();
    write_register(CFG_KEY_LOW, {$urandom, $urandom});
    write_register(CFG_KEY_HIGH, '1);
    send_item(1'b0, any_word(), WordBytes, 1'b0);
    send_item(1'b0, any_word(), 4'd5, 1'b1);
    send_item(1'b0, any_word(), 4'd2, 1'b1);
  endtask

  // One-shot hashes between the words of an open message.
  task automatic test_oneshot_inside_message();
    send_item(1'b0, any_word(), WordBytes, 1'b0);
    send_item(1'b1, any_word(), 4'd8, 1'b1);
    send_item(1'b0, any_word(), WordBytes, 1'b0);
    send_item(1'b1, any_word(), 4'd3, 1'b0);
    send_item(1'b0, any_word(), 4'd6, 1'b1);
  endtask

  // Messages long enough for the block count to wrap, in both shift modes.
  task automatic test_long_messages();
    settle();
    configure({$urandom, $urandom}, {$urandom, $urandom}, 64'd1);
    send_message($urandom_range(256, 280));
    settle();
    configure('1, '1, 64'd0);
    send_message($urandom_range(256, 280));
  endtask

  // Random messages, one-shots and stray items over several register settings.
  task automatic test_random_traffic();
    int unsigned p;
    int unsigned budget;
    int unsigned stop_at;
    for (p = 0; p < RandomPhases; p++) begin
      settle();
      case (p)
        0: configure(64'd0, 64'd0, 64'd0);
        1: configure('1, '1, '1);
        default: configure({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
      endcase
      steady_flow = (p == 2);
      budget  = (ItemTarget > items_sent) ? (ItemTarget - items_sent) / (RandomPhases - p) : 0;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
        case ($urandom_range(99)) inside
          [0:11]:  send_item(1'b1, any_word(), 4'($urandom_range(15)), 1'($urandom_range(1)));
          [12:19]: send_item(1'b0, any_word(), 4'($urandom_range(15)), 1'($urandom_range(1)));
          default: send_message(($urandom_range(99) < 90) ? $urandom_range(6)
                                                           : $urandom_range(7, 40));
        endcase
      end
      steady_flow = 1'b0;
    end
  endtask

  // Result side stalls at random unless traffic is meant to flow freely.
  always @(negedge clk_i) begin
    pop <= rst_ni && (steady_flow || ($urandom_range(99) >= 35));
  end

  // Each digest transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_digests.size() == 0) begin
        note_failure("digest with none expected", 'x, digest_o);
      end else begin
        digest_want = pending_digests.pop_front();
        if (digest_o !== digest_want) note_failure("digest mismatch", digest_want, digest_o);
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    func_i       = 1'b0;
    word_i       = 64'd0;
    byte_count_i = 4'd0;
    last_i       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_KEY_LOW;
    cfg_data_i   = 64'd0;
    key_lo_q     = 64'd0;
    key_hi_q     = 64'd0;
    wide_shift_q = 1'b0;
    msg_lanes    = '0;
    msg_blocks   = 8'd0;
    msg_open     = 1'b0;
    fail_count   = 0;
    items_sent   = 0;
    stall_cycles = 0;
    steady_flow  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_key();
    test_message_tails();
    test_key_change_mid_message();
    test_oneshot_inside_message();
    test_long_messages();
    test_random_traffic();
    settle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
